### design/brcd_pkg.sv
// ----------------------------------------------------------------------------
// brcd_pkg
// Shared types and constants for the bell ring cadence driver.
// ----------------------------------------------------------------------------
package brcd_pkg;

  localparam int unsigned OpWidth    = 2;
  localparam int unsigned CountWidth = 10;
  localparam int unsigned PhaseWidth = 16;
  localparam int unsigned TickWidth  = 8;
  localparam int unsigned AlertWidth = 18;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 16;

  localparam logic [PhaseWidth-1:0] FirstOnRst   = 16'd400;
  localparam logic [PhaseWidth-1:0] ShortOffRst  = 16'd200;
  localparam logic [PhaseWidth-1:0] SecondOnRst  = 16'd400;
  localparam logic [PhaseWidth-1:0] LongOffRst   = 16'd1200;
  localparam logic [TickWidth-1:0]  TogglePerRst = 8'd15;
  localparam logic [TickWidth-1:0]  AlertUnitRst = 8'd50;
  localparam logic [TickWidth-1:0]  ToggleSat    = 8'hFF;

  typedef enum logic [OpWidth-1:0] {
    OpTick  = 2'd0,
    OpStart = 2'd1,
    OpStop  = 2'd2,
    OpAlert = 2'd3
  } op_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgFirstOn   = 3'd0,
    CfgShortOff  = 3'd1,
    CfgSecondOn  = 3'd2,
    CfgLongOff   = 3'd3,
    CfgTogglePer = 3'd4,
    CfgAlertUnit = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    PhFirstOn  = 2'd0,
    PhShortOff = 2'd1,
    PhSecondOn = 2'd2,
    PhLongOff  = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    DriveOff   = 2'b00,
    DriveLeft  = 2'b01,
    DriveRight = 2'b10
  } drive_e;

  typedef struct packed {
    logic drive_left;
    logic drive_right;
    logic ringing;
  } result_t;

endpackage

### design/bell_ring_cadence_driver.sv
// ----------------------------------------------------------------------------
// bell_ring_cadence_driver
// Four-phase ring cadence generator for a bell H-bridge, one request per cycle while the result queue has room.
// ----------------------------------------------------------------------------
// Results: each accepted request's result is registered into the result queue.
// Throughput: one request per cycle while results drain; a two-entry result
//   queue takes one more request while a result waits, then stalls intake
//   until the cycle after a result leaves.
// Reset: rst_ni clears cadence state and the result queue at once and loads
//   the default cadence timing; no clearing pass.
module bell_ring_cadence_driver (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [brcd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [brcd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [brcd_pkg::OpWidth-1:0]        operation_i,
  input  logic [brcd_pkg::CountWidth-1:0]     alert_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                drive_left_o,
  output logic                                drive_right_o,
  output logic                                ringing_o
);
  import brcd_pkg::*;

  logic [PhaseWidth-1:0] first_on_q, short_off_q, second_on_q, long_off_q;
  logic [TickWidth-1:0]  toggle_per_q, alert_unit_q;

  logic                  ring_on_q, ring_on_d;
  logic                  alert_on_q, alert_on_d;
  logic [AlertWidth-1:0] alert_left_q, alert_left_d;
  phase_e                phase_q, phase_d;
  logic [PhaseWidth-1:0] elapsed_q, elapsed_d;
  logic [TickWidth-1:0]  toggle_q, toggle_d;
  logic                  hammer_q, hammer_d;
  logic [1:0]            drive_q, drive_d;

  result_t               queue_q [2];
  logic                  wr_ptr_q, rd_ptr_q;
  logic [1:0]            count_q;

  logic                  push, pop;
  logic [TickWidth-1:0]  toggle_inc;
  logic [PhaseWidth-1:0] phase_len;
  logic [PhaseWidth:0]   elapsed_inc;
  logic [CountWidth-1:0] count_eff;
  logic [AlertWidth-1:0] alert_prod;
  result_t               result;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_on_q   <= FirstOnRst;
      short_off_q  <= ShortOffRst;
      second_on_q  <= SecondOnRst;
      long_off_q   <= LongOffRst;
      toggle_per_q <= TogglePerRst;
      alert_unit_q <= AlertUnitRst;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgFirstOn:   first_on_q   <= cfg_data_i;
        CfgShortOff:  short_off_q  <= cfg_data_i;
        CfgSecondOn:  second_on_q  <= cfg_data_i;
        CfgLongOff:   long_off_q   <= cfg_data_i;
        CfgTogglePer: toggle_per_q <= cfg_data_i[TickWidth-1:0];
        CfgAlertUnit: alert_unit_q <= cfg_data_i[TickWidth-1:0];
        default: ;
      endcase
    end
  end

  assign push       = in_valid_i && !in_stall_o;
  assign pop        = out_valid_o && !out_stall_i;
  assign in_stall_o = (count_q == 2'd2);

  assign toggle_inc  = (toggle_q != ToggleSat) ? toggle_q + 8'd1 : toggle_q;
  assign elapsed_inc = {1'b0, elapsed_q} + 17'd1;
  assign count_eff   = (alert_count_i == '0) ? 10'd1 : alert_count_i;
  assign alert_prod  = {8'b0, count_eff} * {10'b0, alert_unit_q};

  always_comb begin
    unique case (phase_q)
      PhFirstOn:  phase_len = first_on_q;
      PhShortOff: phase_len = short_off_q;
      PhSecondOn: phase_len = second_on_q;
      PhLongOff:  phase_len = long_off_q;
    endcase
  end

  always_comb begin
    ring_on_d    = ring_on_q;
    alert_on_d   = alert_on_q;
    alert_left_d = alert_left_q;
    phase_d      = phase_q;
    elapsed_d    = elapsed_q;
    toggle_d     = toggle_q;
    hammer_d     = hammer_q;
    drive_d      = drive_q;
    unique case (op_e'(operation_i))
      OpTick: begin
        toggle_d = toggle_inc;
        if (alert_on_q) begin
          if (alert_left_q == '0) alert_on_d = 1'b0;
          else alert_left_d = alert_left_q - 18'd1;
        end
        if (ring_on_q || alert_on_d) begin
          if (elapsed_inc >= {1'b0, phase_len}) begin
            phase_d   = phase_e'(phase_q + 2'd1);
            elapsed_d = '0;
          end else begin
            elapsed_d = elapsed_inc[PhaseWidth-1:0];
            if (!phase_q[0]) begin
              if (toggle_inc >= toggle_per_q) begin
                toggle_d = '0;
                drive_d  = hammer_q ? DriveRight : DriveLeft;
                hammer_d = !hammer_q;
              end
            end else begin
              drive_d = DriveOff;
            end
          end
        end else begin
          drive_d = DriveOff;
        end
      end
      OpStart: begin
        ring_on_d = 1'b1;
        phase_d   = PhFirstOn;
        elapsed_d = '0;
      end
      OpStop: begin
        ring_on_d = 1'b0;
        drive_d   = DriveOff;
      end
      OpAlert: begin
        if (!ring_on_q && !alert_on_q) begin
          phase_d   = PhFirstOn;
          elapsed_d = '0;
        end
        alert_left_d = alert_prod + 18'd1;
        alert_on_d   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_on_q    <= 1'b0;
      alert_on_q   <= 1'b0;
      alert_left_q <= '0;
      phase_q      <= PhFirstOn;
      elapsed_q    <= '0;
      toggle_q     <= ToggleSat;
      hammer_q     <= 1'b0;
      drive_q      <= DriveOff;
    end else if (push) begin
      ring_on_q    <= ring_on_d;
      alert_on_q   <= alert_on_d;
      alert_left_q <= alert_left_d;
      phase_q      <= phase_d;
      elapsed_q    <= elapsed_d;
      toggle_q     <= toggle_d;
      hammer_q     <= hammer_d;
      drive_q      <= drive_d;
    end
  end

  assign result.drive_left  = drive_d[0];
  assign result.drive_right = drive_d[1];
  assign result.ringing     = ring_on_d;

  // result queue
  always_ff @(posedge clk_i) begin
    if (push) queue_q[wr_ptr_q] <= result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop)  rd_ptr_q <= !rd_ptr_q;
      if (push && !pop)      count_q <= count_q + 2'd1;
      else if (pop && !push) count_q <= count_q - 2'd1;
    end
  end

  assign out_valid_o   = (count_q != 2'd0);
  assign drive_left_o  = queue_q[rd_ptr_q].drive_left;
  assign drive_right_o = queue_q[rd_ptr_q].drive_right;
  assign ringing_o     = queue_q[rd_ptr_q].ringing;

endmodule

### design/brcd_checker.sv
// ----------------------------------------------------------------------------
// brcd_checker
// Port-level checks for the bell ring cadence driver, bound to the top level.
// ----------------------------------------------------------------------------
module brcd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic [brcd_pkg::OpWidth-1:0]    operation_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic                            drive_left_o,
  input logic                            drive_right_o,
  input logic                            ringing_o
);
  import brcd_pkg::*;

  logic in_acc;
  assign in_acc = in_valid_i && !in_stall_o;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o &&
      $stable({drive_left_o, drive_right_o, ringing_o}))
    else $error("stalled result changed");

  a_no_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(drive_left_o && drive_right_o))
    else $error("both bridge legs high");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(out_valid_o && out_stall_i))
    else $error("intake stalled without waiting result");

  a_stop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (operation_i == OpStop) |=>
      out_valid_o && !ringing_o && !drive_left_o && !drive_right_o)
    else $error("stop did not silence bell");

  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !out_valid_o && (operation_i == OpStart) |=> out_valid_o && ringing_o)
    else $error("start did not set ringing");

endmodule

bind bell_ring_cadence_driver brcd_checker u_brcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .operation_i   (operation_i),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .drive_left_o  (drive_left_o),
  .drive_right_o (drive_right_o),
  .ringing_o     (ringing_o)
);
